[hdl/spherical_soft_mask_macros.svh]
// Assertion helpers shared by ssm_queue and ssm_back.
// All checks run on i_clk and are held off while i_rst_n is low.
`ifndef SPHERICAL_SOFT_MASK_MACROS_SVH
`define SPHERICAL_SOFT_MASK_MACROS_SVH

// Same-cycle implication.
`define SSM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssm check failed");

// Next-cycle implication.
`define SSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssm check failed");

`endif

[hdl/ssm_pkg.sv]
package ssm_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COS_DEPTH_DEF   = 256;

    localparam int CENTER_W   = 14;
    localparam int LEN_W      = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_ADDR_W = 3;
    localparam int WEIGHT_W   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Z   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TAPER      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_USE_SAMPLE = 3'd6;

    // voxel class decided by the front end
    localparam int CLS_W = 2;
    localparam logic [CLS_W-1:0] CLS_IN    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_OUT   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_SHELL = 2'd2;

    localparam logic [WEIGHT_W-1:0] ONE_Q15 = 16'h8000;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    // (2n-1)*2n for the cosine series
    localparam logic [7:0] TAYLOR_DEN [8] = '{8'd2, 8'd12, 8'd30, 8'd56,
                                              8'd90, 8'd132, 8'd182, 8'd240};

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [CENTER_W-1:0] center_z;
        logic [LEN_W-1:0]    radius;
        logic [LEN_W-1:0]    taper;
        logic                invert;
        logic                use_sample;
    } t_cfg;

    // width of the squared distance for a given coordinate width
    function automatic int dsq_width(input int cb);
        int mw;
        mw = (cb + 4 > CENTER_W) ? cb + 4 : CENTER_W;
        return 2 * mw + 2;
    endfunction

endpackage

[hdl/spherical_soft_mask.sv]
// An input beat passes the front stages, the queue, the root stages (one bit
// each of the root of the squared distance times 256), the offset stage, the
// divide stages (one cosine-table index bit each), then lookup, multiply, output.
// Throughput: one beat per cycle, set by the fully pipelined root and divider.
// The back end freezes as a whole on output backpressure; a 4-entry queue
// decouples it from the front end. Reset is synchronous, active low: it
// empties the pipeline and queue and loads the register reset values.
module spherical_soft_mask #(
    parameter int COORD_BITS      = ssm_pkg::COORD_BITS_DEF,
    parameter int SAMPLE_BITS     = ssm_pkg::SAMPLE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = ssm_pkg::COS_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ssm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // coord_x, coord_y, coord_z, sample_value
    input  logic [((3*COORD_BITS+SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // masked_value, mask_weight
    output logic [((SAMPLE_BITS+16+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CB   = COORD_BITS;
    localparam int SB   = SAMPLE_BITS;
    localparam int DSQW = ssm_pkg::dsq_width(COORD_BITS);
    localparam int QW   = SB + DSQW + ssm_pkg::CLS_W;
    localparam int OUTW = ((SAMPLE_BITS + 16 + 7) / 8) * 8;

    ssm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{center_x: '0, center_y: '0, center_z: '0, radius: '0,
                       taper: '0, invert: 1'b0, use_sample: 1'b1};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                ssm_pkg::REG_CENTER_X:   r_cfg.center_x   <= i_cfg_data[13:0];
                ssm_pkg::REG_CENTER_Y:   r_cfg.center_y   <= i_cfg_data[13:0];
                ssm_pkg::REG_CENTER_Z:   r_cfg.center_z   <= i_cfg_data[13:0];
                ssm_pkg::REG_RADIUS:     r_cfg.radius     <= i_cfg_data;
                ssm_pkg::REG_TAPER:      r_cfg.taper      <= i_cfg_data;
                ssm_pkg::REG_INVERT:     r_cfg.invert     <= i_cfg_data[0];
                ssm_pkg::REG_USE_SAMPLE: r_cfg.use_sample <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic                       w_push, w_full, w_pop, w_empty;
    logic [DSQW-1:0]            w_f_dsq, w_b_dsq;
    logic [ssm_pkg::CLS_W-1:0]  w_f_cls, w_b_cls;
    logic signed [SB-1:0]       w_f_smp, w_b_smp;
    logic [QW-1:0]              w_q_out;
    logic signed [SB-1:0]       w_masked;
    logic [ssm_pkg::WEIGHT_W-1:0] w_weight;

    ssm_front #(
        .COORD_BITS  (COORD_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_coord_x (i_s_axis_tdata[CB-1:0]),
        .i_coord_y (i_s_axis_tdata[2*CB-1:CB]),
        .i_coord_z (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_sample  ($signed(i_s_axis_tdata[3*CB+SB-1:3*CB])),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_dsq     (w_f_dsq),
        .o_cls     (w_f_cls),
        .o_sample  (w_f_smp)
    );

    ssm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_smp, w_f_dsq, w_f_cls}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_q_out)
    );

    assign w_b_cls = w_q_out[ssm_pkg::CLS_W-1:0];
    assign w_b_dsq = w_q_out[ssm_pkg::CLS_W+DSQW-1:ssm_pkg::CLS_W];
    assign w_b_smp = $signed(w_q_out[QW-1:ssm_pkg::CLS_W+DSQW]);

    ssm_back #(
        .COORD_BITS      (COORD_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_dsq    (w_b_dsq),
        .i_cls    (w_b_cls),
        .i_sample (w_b_smp),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_masked (w_masked),
        .o_weight (w_weight)
    );

    assign o_m_axis_tdata = OUTW'({w_weight, w_masked});

endmodule

[hdl/ssm_front.sv]
module ssm_front #(
    parameter int COORD_BITS  = ssm_pkg::COORD_BITS_DEF,
    parameter int SAMPLE_BITS = ssm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  ssm_pkg::t_cfg                              i_cfg,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [COORD_BITS-1:0]                      i_coord_x,
    input  logic [COORD_BITS-1:0]                      i_coord_y,
    input  logic [COORD_BITS-1:0]                      i_coord_z,
    input  logic signed [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                       i_full,
    output logic                                       o_push,
    output logic [ssm_pkg::dsq_width(COORD_BITS)-1:0]  o_dsq,
    output logic [ssm_pkg::CLS_W-1:0]                  o_cls,
    output logic signed [SAMPLE_BITS-1:0]              o_sample
);

    localparam int DSQW = ssm_pkg::dsq_width(COORD_BITS);
    localparam int MW   = (DSQW - 2) / 2;
    localparam int CW   = (DSQW > 32) ? DSQW : 32;

    function automatic logic [2*MW-1:0] axis_sq(input logic [COORD_BITS-1:0] c,
                                                input logic [ssm_pkg::CENTER_W-1:0] ctr);
        logic signed [MW:0] d;
        logic [MW-1:0]      m;
        d = $signed({1'b0, MW'({c, 4'b0000})}) - $signed({1'b0, MW'(ctr)});
        m = d[MW] ? MW'(-d) : d[MW-1:0];
        return m * m;
    endfunction

    logic                    c_en;
    logic                    r_f1_valid;
    logic [2*MW-1:0]         r_f1_sqx, r_f1_sqy, r_f1_sqz;
    logic signed [SAMPLE_BITS-1:0] r_f1_smp;
    logic                    r_f2_valid;
    logic [DSQW-1:0]         r_f2_dsq;
    logic [ssm_pkg::CLS_W-1:0] r_f2_cls;
    logic signed [SAMPLE_BITS-1:0] r_f2_smp;
    logic [29:0]             r_rsq;
    logic [31:0]             r_rtsq;
    logic [15:0]             c_rt;
    logic [DSQW-1:0]         c_dsq;
    logic [CW-1:0]           c_dsq_x;
    logic [ssm_pkg::CLS_W-1:0] c_cls;

    assign c_en    = !r_f2_valid || !i_full;
    assign o_ready = c_en;
    assign o_push  = r_f2_valid && !i_full;
    assign o_dsq    = r_f2_dsq;
    assign o_cls    = r_f2_cls;
    assign o_sample = r_f2_smp;

    assign c_rt = 16'(i_cfg.radius) + 16'(i_cfg.taper);

    always_comb begin
        c_dsq   = DSQW'(r_f1_sqx) + DSQW'(r_f1_sqy) + DSQW'(r_f1_sqz);
        c_dsq_x = CW'(c_dsq);
        if (c_dsq_x <= CW'(r_rsq)) begin
            c_cls = ssm_pkg::CLS_IN;
        end else if (i_cfg.taper == '0 || c_dsq_x > CW'(r_rtsq)) begin
            c_cls = ssm_pkg::CLS_OUT;
        end else begin
            c_cls = ssm_pkg::CLS_SHELL;
        end
    end

    // the user must keep config static while items are in flight; the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_rsq  <= i_cfg.radius * i_cfg.radius;
        r_rtsq <= c_rt * c_rt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (c_en) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_f1_sqx <= axis_sq(i_coord_x, i_cfg.center_x);
            r_f1_sqy <= axis_sq(i_coord_y, i_cfg.center_y);
            r_f1_sqz <= axis_sq(i_coord_z, i_cfg.center_z);
            r_f1_smp <= i_sample;
            r_f2_dsq <= c_dsq;
            r_f2_cls <= c_cls;
            r_f2_smp <= r_f1_smp;
        end
    end

endmodule

[hdl/ssm_queue.sv]
`include "spherical_soft_mask_macros.svh"

module ssm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = ssm_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CNTW-1:0]  r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= AW'(r_wptr + 1'b1);
            if (i_pop)  r_rptr <= AW'(r_rptr + 1'b1);
            if (i_push && !i_pop)      r_count <= CNTW'(r_count + 1'b1);
            else if (!i_push && i_pop) r_count <= CNTW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

    `SSM_ASSERT_IMPL(a_q_count, 1'b1, r_count <= CNTW'(DEPTH))

endmodule

[hdl/ssm_back.sv]
`include "spherical_soft_mask_macros.svh"

module ssm_back #(
    parameter int COORD_BITS      = ssm_pkg::COORD_BITS_DEF,
    parameter int SAMPLE_BITS     = ssm_pkg::SAMPLE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = ssm_pkg::COS_DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  ssm_pkg::t_cfg                              i_cfg,
    input  logic                                       i_empty,
    output logic                                       o_pop,
    input  logic [ssm_pkg::dsq_width(COORD_BITS)-1:0]  i_dsq,
    input  logic [ssm_pkg::CLS_W-1:0]                  i_cls,
    input  logic signed [SAMPLE_BITS-1:0]              i_sample,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic signed [SAMPLE_BITS-1:0]              o_masked,
    output logic [ssm_pkg::WEIGHT_W-1:0]               o_weight
);

    localparam int DSQW = ssm_pkg::dsq_width(COORD_BITS);
    localparam int RW   = (DSQW + 9) / 2;           // root bits of dsq*256
    localparam int RMW  = RW + 2;
    localparam int DB   = $clog2(COS_TABLE_DEPTH + 1);
    localparam int QB   = DB;
    localparam int NUMW = RW + DB + 2;
    localparam int DIVW = ssm_pkg::LEN_W + 5;
    localparam int PW   = SAMPLE_BITS + 17;
    localparam int CLSW = ssm_pkg::CLS_W;
    localparam int SB   = SAMPLE_BITS;
    localparam int WW   = ssm_pkg::WEIGHT_W;

    typedef logic [WW-1:0] t_rom [COS_TABLE_DEPTH+1];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] a, x, x2, term;
        longint      sum, tt;
        logic        flip;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
            flip = (2 * i > COS_TABLE_DEPTH);
            a    = flip ? 64'(COS_TABLE_DEPTH - i) : 64'(i);
            x    = ssm_pkg::PI_Q30 * a / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = ssm_pkg::Q30_ONE;
            sum  = longint'(ssm_pkg::Q30_ONE);
            for (int n = 0; n < 8; n++) begin
                term = ((term * x2) >> 30) / ssm_pkg::TAYLOR_DEN[n];
                if (n % 2 == 0) sum = sum - longint'(term);
                else            sum = sum + longint'(term);
            end
            if (flip) sum = -sum;
            tt = longint'(ssm_pkg::Q30_ONE) + sum;
            if (tt < 0) tt = 0;
            tt = (tt + 32768) >>> 16;
            if (tt > 32768) tt = 32768;
            rom[i] = WW'(tt);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_rom();

    localparam logic signed [PW:0] SMAX = (PW+1)'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [PW:0] SMIN = ~SMAX;

    logic c_en;
    assign c_en  = !o_valid || i_ready;
    assign o_pop = c_en && !i_empty;

    // square root, one result bit per stage
    logic                 r_sq_vld  [RW];
    logic [RW-1:0]        r_sq_root [RW];
    logic [RMW-1:0]       r_sq_rem  [RW];
    logic [2*RW-1:0]      r_sq_rad  [RW];
    logic [CLSW-1:0]      r_sq_cls  [RW];
    logic signed [SB-1:0] r_sq_smp  [RW];

    for (genvar s = 0; s < RW; s++) begin : g_sq
        logic                 vld_i;
        logic [RW-1:0]        root_i;
        logic [RMW-1:0]       rem_i, rem2, trial;
        logic [2*RW-1:0]      rad_i;
        logic [CLSW-1:0]      cls_i;
        logic signed [SB-1:0] smp_i;
        if (s == 0) begin : g_first
            assign vld_i  = !i_empty;
            assign root_i = '0;
            assign rem_i  = '0;
            assign rad_i  = (2*RW)'({i_dsq, 8'h00});
            assign cls_i  = i_cls;
            assign smp_i  = i_sample;
        end else begin : g_next
            assign vld_i  = r_sq_vld[s-1];
            assign root_i = r_sq_root[s-1];
            assign rem_i  = r_sq_rem[s-1];
            assign rad_i  = r_sq_rad[s-1];
            assign cls_i  = r_sq_cls[s-1];
            assign smp_i  = r_sq_smp[s-1];
        end
        assign rem2  = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
        assign trial = {root_i, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_vld[s] <= 1'b0;
            else if (c_en) r_sq_vld[s] <= vld_i;
        end
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                if (rem2 >= trial) begin
                    r_sq_rem[s]  <= rem2 - trial;
                    r_sq_root[s] <= {root_i[RW-2:0], 1'b1};
                end else begin
                    r_sq_rem[s]  <= rem2;
                    r_sq_root[s] <= {root_i[RW-2:0], 1'b0};
                end
                r_sq_rad[s] <= {rad_i[2*RW-3:0], 2'b00};
                r_sq_cls[s] <= cls_i;
                r_sq_smp[s] <= smp_i;
            end
        end
    end

    // offset into the shell and dividend
    logic [RW-1:0]        c_r16, c_off, c_dist;
    logic [DIVW-1:0]      c_div;
    logic                 r_pp_vld;
    logic [NUMW-1:0]      r_pp_num;
    logic [CLSW-1:0]      r_pp_cls;
    logic signed [SB-1:0] r_pp_smp;

    assign c_dist = r_sq_root[RW-1];
    assign c_r16  = RW'({i_cfg.radius, 4'h0});
    assign c_off  = (c_dist > c_r16) ? RW'(c_dist - c_r16) : '0;
    assign c_div  = {i_cfg.taper, 5'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pp_vld <= 1'b0;
        else if (c_en) r_pp_vld <= r_sq_vld[RW-1];
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_pp_num <= NUMW'((NUMW'(c_off) * NUMW'(COS_TABLE_DEPTH)) << 1)
                      + NUMW'({i_cfg.taper, 4'h0});
            r_pp_cls <= r_sq_cls[RW-1];
            r_pp_smp <= r_sq_smp[RW-1];
        end
    end

    // restoring division by 32*taper, one quotient bit per stage
    logic                 r_dv_vld [QB];
    logic [NUMW-1:0]      r_dv_rem [QB];
    logic [QB-1:0]        r_dv_q   [QB];
    logic [CLSW-1:0]      r_dv_cls [QB];
    logic signed [SB-1:0] r_dv_smp [QB];

    for (genvar s = 0; s < QB; s++) begin : g_dv
        localparam int K = QB - 1 - s;
        logic                 vld_i;
        logic [NUMW-1:0]      rem_i, trial;
        logic [QB-1:0]        q_i;
        logic [CLSW-1:0]      cls_i;
        logic signed [SB-1:0] smp_i;
        if (s == 0) begin : g_first
            assign vld_i = r_pp_vld;
            assign rem_i = r_pp_num;
            assign q_i   = '0;
            assign cls_i = r_pp_cls;
            assign smp_i = r_pp_smp;
        end else begin : g_next
            assign vld_i = r_dv_vld[s-1];
            assign rem_i = r_dv_rem[s-1];
            assign q_i   = r_dv_q[s-1];
            assign cls_i = r_dv_cls[s-1];
            assign smp_i = r_dv_smp[s-1];
        end
        assign trial = NUMW'(c_div) << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_vld[s] <= 1'b0;
            else if (c_en) r_dv_vld[s] <= vld_i;
        end
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                if (rem_i >= trial) begin
                    r_dv_rem[s] <= rem_i - trial;
                    r_dv_q[s]   <= {q_i[QB-2:0], 1'b1};
                end else begin
                    r_dv_rem[s] <= rem_i;
                    r_dv_q[s]   <= {q_i[QB-2:0], 1'b0};
                end
                r_dv_cls[s] <= cls_i;
                r_dv_smp[s] <= smp_i;
            end
        end
    end

    // table lookup and weight select
    logic [DB-1:0]        c_idx;
    logic [WW-1:0]        c_w, c_wsel;
    logic                 r_rm_vld;
    logic [WW-1:0]        r_rm_w;
    logic [CLSW-1:0]      r_rm_cls;
    logic signed [SB-1:0] r_rm_smp;

    assign c_idx = (r_dv_q[QB-1] > DB'(COS_TABLE_DEPTH)) ? DB'(COS_TABLE_DEPTH)
                                                         : r_dv_q[QB-1];
    always_comb begin
        case (r_dv_cls[QB-1])
            ssm_pkg::CLS_IN:    c_wsel = ssm_pkg::ONE_Q15;
            ssm_pkg::CLS_SHELL: c_wsel = COS_ROM[c_idx];
            default:            c_wsel = '0;
        endcase
        c_w = i_cfg.invert ? WW'(ssm_pkg::ONE_Q15 - c_wsel) : c_wsel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rm_vld <= 1'b0;
        else if (c_en) r_rm_vld <= r_dv_vld[QB-1];
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_rm_w   <= c_w;
            r_rm_cls <= r_dv_cls[QB-1];
            r_rm_smp <= r_dv_smp[QB-1];
        end
    end

    // sample times weight
    logic                 r_mu_vld;
    logic signed [PW-1:0] r_prod;
    logic [WW-1:0]        r_mu_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mu_vld <= 1'b0;
        else if (c_en) r_mu_vld <= r_rm_vld;
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_prod <= r_rm_smp * $signed({1'b0, r_rm_w});
            r_mu_w <= r_rm_w;
        end
    end

    // round half up, pick product or weight, saturate
    logic signed [PW:0]   c_rnd, c_q, c_wx, c_sel;
    logic signed [SB-1:0] c_res;
    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_val;
    logic [WW-1:0]        r_out_w;

    always_comb begin
        c_rnd = $signed({r_prod[PW-1], r_prod} + (PW+1)'(16384));
        c_q   = c_rnd >>> 15;
        c_wx  = $signed((PW+1)'(r_mu_w));
        c_sel = i_cfg.use_sample ? c_q : c_wx;
        if (c_sel > SMAX)      c_res = SMAX[SB-1:0];
        else if (c_sel < SMIN) c_res = SMIN[SB-1:0];
        else                   c_res = c_sel[SB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (c_en) r_out_valid <= r_mu_vld;
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_out_val <= c_res;
            r_out_w   <= r_mu_w;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_masked = r_out_val;
    assign o_weight = r_out_w;

    `SSM_ASSERT_IMPL(a_w_range, r_out_valid, r_out_w <= ssm_pkg::ONE_Q15)
    `SSM_ASSERT_NEXT(a_hold, !c_en && r_mu_vld, $stable(r_mu_vld) && $stable(r_prod))
    `SSM_ASSERT_IMPL(a_inside_one, r_rm_vld && r_rm_cls == ssm_pkg::CLS_IN && !i_cfg.invert,
                     r_rm_w == ssm_pkg::ONE_Q15)

endmodule
